// File: hw/rtl/idiv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idiv_pkg
// Shared types and constants for the 32-bit restoring integer divider.
// ----------------------------------------------------------------------------
package idiv_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);
  localparam int unsigned FUNC_W = 2;

  // Operation selector codes carried on in_tuser.
  localparam logic [FUNC_W-1:0] FUNC_UQUO = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UREM = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SQUO = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIX
  } idiv_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } idiv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } idiv_status_t;

endpackage

// File: hw/rtl/idiv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idiv_ctrl
// Sequencer for the divider: load, 32 shift-subtract steps, then result.
// ----------------------------------------------------------------------------
module idiv_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  output idiv_pkg::idiv_cmd_t     cmd,
  input  idiv_pkg::idiv_status_t  status
);
  import idiv_pkg::*;

  idiv_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // An accepted beat always starts the step sequence from the first step.
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_CALC) && (cnt_r == '0))
    else $error("load did not start the step sequence");

  // The last step hands over to the result stage.
  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) && (cnt_r == LAST_STEP) |=> (state_r == ST_FIX))
    else $error("last step did not reach the result stage");

  // No new beat is taken while a division is in progress.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_ready && !cmd.load)
    else $error("input accepted during a division");

endmodule

// File: hw/rtl/idiv_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idiv_dpath
// Operand registers, restoring shift-subtract step and output register.
// ----------------------------------------------------------------------------
module idiv_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  idiv_pkg::idiv_cmd_t               cmd,
  output idiv_pkg::idiv_status_t            status,
  input  logic [idiv_pkg::FUNC_W-1:0]       func,
  input  logic [idiv_pkg::WORD_W-1:0]       dividend_word,
  input  logic [idiv_pkg::WORD_W-1:0]       divisor_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [idiv_pkg::WORD_W-1:0]       result_word,
  output logic                              div_by_zero
);
  import idiv_pkg::*;

  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] den_r;
  logic              neg_r, sel_rem_r, dz_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r;
  logic              out_dz_r;

  logic              is_signed, is_rem;
  logic [WORD_W-1:0] abs_n, abs_d, fin_res;
  logic [WORD_W:0]   shifted;
  logic [WORD_W+1:0] diff;
  logic              take;

  always_comb begin
    unique case (func)
      FUNC_UQUO: begin is_signed = 1'b0; is_rem = 1'b0; end
      FUNC_UREM: begin is_signed = 1'b0; is_rem = 1'b1; end
      FUNC_SQUO: begin is_signed = 1'b1; is_rem = 1'b0; end
      FUNC_RSVD: begin is_signed = 1'b1; is_rem = 1'b0; end
      default:   begin is_signed = 1'b0; is_rem = 1'b0; end
    endcase
  end

  assign abs_n = (is_signed && dividend_word[WORD_W-1]) ? (~dividend_word + WORD_W'(1))
                                                        : dividend_word;
  assign abs_d = (is_signed && divisor_word[WORD_W-1]) ? (~divisor_word + WORD_W'(1))
                                                       : divisor_word;

  // One restoring step: bring down the next dividend bit and trial-subtract.
  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign take    = ~diff[WORD_W+1];
  assign rem_nxt = take ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
  assign quo_nxt = {quo_r[WORD_W-2:0], take};

  always_comb begin
    priority if (dz_r) begin
      fin_res = '1;
    end else if (sel_rem_r) begin
      fin_res = rem_r;
    end else if (neg_r) begin
      fin_res = ~quo_r + WORD_W'(1);
    end else begin
      fin_res = quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r     <= abs_n;
      den_r     <= abs_d;
      rem_r     <= '0;
      neg_r     <= is_signed && (dividend_word[WORD_W-1] ^ divisor_word[WORD_W-1]);
      sel_rem_r <= is_rem;
      dz_r      <= (divisor_word == '0);
    end else if (cmd.step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.finish) begin
      out_data_r <= fin_res;
      out_dz_r   <= dz_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign result_word     = out_data_r;
  assign div_by_zero     = out_dz_r;

  // A result is only written when the output register is empty or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // A finished division always shows up on the output.
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished result not presented");

  // A zero divisor always yields an all-ones word.
  a_dz_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dz_r) |-> (out_data_r == '1))
    else $error("divide by zero result not all ones");

endmodule

// File: hw/rtl/integer_divider_32_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_divider_32_unit
// 32-bit integer divider: unsigned quotient, unsigned remainder or signed
// quotient, one result beat per input beat.
// ----------------------------------------------------------------------------
// Usage notes.
// Each input beat carries a dividend and a divisor on in_tdata and the
// operation on in_tuser. Each one produces exactly one output beat holding
// the result word on out_tdata and a divide-by-zero flag on out_tuser.
// A beat is taken only while the divider is idle. The division itself is a
// restoring shift-subtract loop that retires one quotient bit per cycle, so
// the 32 steps set the pace: the magnitudes are loaded at the accepting
// edge, then come the 32 steps, and then the sign-fix stage applies the sign
// and writes the output register. The next beat is accepted only once the
// sequencer is back in idle.
// The output register decouples the two sides: the divider takes the next
// beat while an earlier result still waits. If the receiver stalls, the
// finished result waits in the sign-fix stage until the register frees.
// Signed quotients truncate toward zero; the most negative value divided by
// minus one wraps to itself. A zero divisor gives all ones with the flag set.
// Synchronous reset empties the output register and idles the sequencer.
// ----------------------------------------------------------------------------
module integer_divider_32_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2*idiv_pkg::WORD_W-1:0]   in_tdata,  // divisor_word (upper half), dividend_word (lower half)
  input  logic [idiv_pkg::FUNC_W-1:0]     in_tuser,  // func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [idiv_pkg::WORD_W-1:0]     out_tdata, // result_word
  output logic                            out_tuser  // div_by_zero
);
  import idiv_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  idiv_cmd_t    cmd;
  idiv_status_t status;

  // The sequencer owns the input handshake and the step count.
  idiv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // The datapath holds the operands, the shift-subtract step and the
  // output register with its valid flag.
  idiv_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .func          (in_tuser),
    .dividend_word (in_tdata[WORD_W-1:0]),
    .divisor_word  (in_tdata[2*WORD_W-1:WORD_W]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .result_word   (out_tdata),
    .div_by_zero   (out_tuser)
  );

endmodule
